// ----- hdl/tp_pkg.sv -----
// Shared widths and constants for the triangle perimeter pipeline.
package tp_pkg;

    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = 8;
    localparam int PERIM_W     = 27;

    localparam int ABS_W       = COORD_BITS;
    localparam int SQ_W        = 2 * COORD_BITS + 1;
    localparam int RAD_W       = SQ_W + 2 * FRAC_BITS;
    localparam int ROOT_W      = (RAD_W + 1) / 2;
    localparam int RAD_EW      = 2 * ROOT_W;
    localparam int REM_W       = ROOT_W + 3;

    localparam int NUM_SIDES   = 3;
    localparam int SQRT_FIRST  = 3;
    localparam int NUM_STAGES  = SQRT_FIRST + ROOT_W + 1;

    localparam int IN_W        = 6 * COORD_BITS;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((PERIM_W + 7) / 8) * 8;

    localparam int SUM_W       = ROOT_W + 2;
    localparam int SUMX_W      = (SUM_W > PERIM_W) ? SUM_W : PERIM_W;

endpackage

// ----- hdl/tp_isqrt_pipe.sv -----
// Pipelined restoring integer square root, one root bit per register stage.
module tp_isqrt_pipe (
    input  logic                      i_clk,
    input  logic [tp_pkg::ROOT_W-1:0] i_en,
    input  logic [tp_pkg::RAD_W-1:0]  i_rad,
    output logic [tp_pkg::ROOT_W-1:0] o_root
);
    import tp_pkg::*;

    logic [RAD_EW-1:0] r_rad  [ROOT_W-1];
    logic [REM_W-1:0]  r_rem  [ROOT_W-1];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    logic [RAD_EW-1:0] n_rad  [ROOT_W];
    logic [REM_W-1:0]  n_rem  [ROOT_W];
    logic [ROOT_W-1:0] n_root [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [RAD_EW-1:0] w_rad_in;
        logic [REM_W-1:0]  w_rem_in;
        logic [ROOT_W-1:0] w_root_in;

        if (k == 0) begin : g_first
            assign w_rad_in  = RAD_EW'(i_rad);
            assign w_rem_in  = '0;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rad_in  = r_rad[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
        end

        // Bring down the next pair of radicand bits and try the 4*root+1 subtrahend.
        always_comb begin
            logic [REM_W-1:0] rem_sh;
            logic [REM_W-1:0] trial;
            rem_sh   = {w_rem_in[REM_W-3:0], w_rad_in[RAD_EW-1 -: 2]};
            trial    = REM_W'({w_root_in, 2'b01});
            n_rad[k] = w_rad_in << 2;
            if (rem_sh >= trial) begin
                n_rem[k]  = rem_sh - trial;
                n_root[k] = {w_root_in[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = rem_sh;
                n_root[k] = {w_root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_root[k] <= n_root[k];
            end
        end

        if (k < ROOT_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_rad[k] <= n_rad[k];
                    r_rem[k] <= n_rem[k];
                end
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

// ----- hdl/triangle_perimeter_top.sv -----
// Top level of the triangle perimeter pipeline: stream ports, side lengths and final sum.
// A word accepted at the input passes through the stage registers to the output; one word is
// accepted every cycle while the output is not back-pressured.
// The depth is set by the square root units, which resolve one root bit per stage.
// Each stage advances when it is empty or the next stage advances, so bubbles close up under
// backpressure. The synchronous active-low reset clears only the stage valid bits.
module triangle_perimeter_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0 up: ax, ay, bx, by_coord, cx, cy (COORD_BITS each, signed).
    input  logic [tp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Fields from bit 0 up: perimeter (PERIM_W bits, unsigned), zero fill above.
    output logic [tp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import tp_pkg::*;

    // Absolute difference of two signed coordinates; the result always fits ABS_W bits.
    function automatic logic [ABS_W-1:0] abs_diff(input logic [COORD_BITS-1:0] p,
                                                 input logic [COORD_BITS-1:0] q);
        logic signed [COORD_BITS:0] d;
        logic signed [COORD_BITS:0] m;
        d = $signed({p[COORD_BITS-1], p}) - $signed({q[COORD_BITS-1], q});
        m = d[COORD_BITS] ? -d : d;
        return m[ABS_W-1:0];
    endfunction

    // Coordinates unpacked from the input word.
    logic [COORD_BITS-1:0] w_ax, w_ay, w_bx, w_by, w_cx, w_cy;

    assign w_ax = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
    assign w_ay = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
    assign w_bx = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
    assign w_by = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
    assign w_cx = s_axis_tdata[4*COORD_BITS +: COORD_BITS];
    assign w_cy = s_axis_tdata[5*COORD_BITS +: COORD_BITS];

    // Stage valid bits and per-stage advance enables.
    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] w_en;

    // A stage loads when it holds nothing or its contents move on this cycle.
    always_comb begin
        w_en[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    assign s_axis_tready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // Stage 0: absolute coordinate differences for sides A-B, A-C and C-B.
    logic [ABS_W-1:0] r_dx [NUM_SIDES];
    logic [ABS_W-1:0] r_dy [NUM_SIDES];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_dx[0] <= abs_diff(w_ax, w_bx);
            r_dy[0] <= abs_diff(w_ay, w_by);
            r_dx[1] <= abs_diff(w_ax, w_cx);
            r_dy[1] <= abs_diff(w_ay, w_cy);
            r_dx[2] <= abs_diff(w_cx, w_bx);
            r_dy[2] <= abs_diff(w_cy, w_by);
        end
    end

    // Stage 1: squares, one multiplier per coordinate difference.
    logic [2*ABS_W-1:0] r_sqx [NUM_SIDES];
    logic [2*ABS_W-1:0] r_sqy [NUM_SIDES];

    // Stage 2: sum of squares scaled by 2^(2*FRAC_BITS), the square root radicand.
    logic [RAD_W-1:0] r_rad [NUM_SIDES];

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NUM_SIDES; s++) begin
            if (w_en[1]) begin
                r_sqx[s] <= r_dx[s] * r_dx[s];
                r_sqy[s] <= r_dy[s] * r_dy[s];
            end
            if (w_en[2]) begin
                r_rad[s] <= (RAD_W'(r_sqx[s]) + RAD_W'(r_sqy[s])) << (2 * FRAC_BITS);
            end
        end
    end

    // Square root stages: one pipelined unit per side, sharing the stage enables.
    logic [ROOT_W-1:0] w_root [NUM_SIDES];

    for (genvar s = 0; s < NUM_SIDES; s++) begin : g_side
        tp_isqrt_pipe u_isqrt (
            .i_clk  (i_clk),
            .i_en   (w_en[SQRT_FIRST +: ROOT_W]),
            .i_rad  (r_rad[s]),
            .o_root (w_root[s])
        );
    end

    // Final stage: sum of the three truncated side lengths, wrapped to the output width.
    logic [SUMX_W-1:0]  n_sum;
    logic [PERIM_W-1:0] r_perim;

    assign n_sum = SUMX_W'(w_root[0]) + SUMX_W'(w_root[1]) + SUMX_W'(w_root[2]);

    always_ff @(posedge i_clk) begin
        if (w_en[NUM_STAGES-1]) begin
            r_perim <= n_sum[PERIM_W-1:0];
        end
    end

    assign m_axis_tvalid = r_valid[NUM_STAGES-1];
    assign m_axis_tdata  = OUT_TDATA_W'(r_perim);

    // An empty entry stage must always be able to take a word.
    a_entry_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[0] |-> s_axis_tready)
        else $error("entry stage empty but input not ready");

    // With no result waiting at the output, every stage must advance.
    a_all_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> (&w_en))
        else $error("pipeline stalled without output backpressure");

    // A stalled output stage holds its word and its valid bit.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[NUM_STAGES-1] && !w_en[NUM_STAGES-1]) |=>
            (r_valid[NUM_STAGES-1] && $stable(r_perim)))
        else $error("stalled result lost or changed");

endmodule

// ----- tb/sv/triangle_perimeter_top_tb.sv -----
// Self-checking testbench for the triangle perimeter pipeline with stream stimulus and scoreboard.
`timescale 1ns / 1ps

module triangle_perimeter_top_tb;

    import tp_pkg::*;

    // Coordinate extremes: most negative, most positive and minus one.
    localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] COORD_NEG1 = {COORD_BITS{1'b1}};

    // The long receiver hold must outlast the pipeline depth so the input side stalls.
    localparam int LONG_HOLD    = 400;
    // Cycles to wait after the last expected word, to catch any stray extra output word.
    localparam int DRAIN_CYCLES = 2 * NUM_STAGES + 20;
    // Hard stop: a time limit far above the slowest correct run.
    localparam realtime RUN_LIMIT = 10ms;

    // Point generation styles for the random part.
    typedef enum int {
        PTS_UNIFORM,
        PTS_CLUSTER,
        PTS_EXTREME,
        PTS_COINCIDENT
    } t_pts_style;

    // Holds the perimeters still due on the output and counts mismatches.
    class perimeter_board;
        logic [PERIM_W-1:0] due_q[$];
        int mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Exact floor square root of a value below 2^64, one root bit at a time.
        function logic [63:0] floor_sqrt(logic [63:0] rad);
            logic [63:0]  root;
            logic [63:0]  trial;
            logic [127:0] wide;
            root = '0;
            for (int b = 63; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                wide  = {64'd0, trial};
                if (wide * wide <= {64'd0, rad}) begin
                    root = trial;
                end
            end
            return root;
        endfunction

        // Length of one side in fixed point with FRAC_BITS fraction bits, truncated.
        function logic [63:0] side_length(longint x1, longint y1, longint x2, longint y2);
            longint      dx;
            longint      dy;
            logic [63:0] sq;
            dx = (x1 >= x2) ? x1 - x2 : x2 - x1;
            dy = (y1 >= y2) ? y1 - y2 : y2 - y1;
            sq = dx * dx + dy * dy;
            return floor_sqrt(sq << (2 * FRAC_BITS));
        endfunction

        // Perimeter of the triangle packed in one input word, wrapped to the output width.
        function logic [PERIM_W-1:0] perimeter_of(logic [IN_TDATA_W-1:0] w);
            longint      c[6];
            logic [63:0] total;
            for (int k = 0; k < 6; k++) begin
                c[k] = $signed(w[k*COORD_BITS +: COORD_BITS]);
            end
            total = side_length(c[0], c[1], c[2], c[3])
                  + side_length(c[0], c[1], c[4], c[5])
                  + side_length(c[4], c[5], c[2], c[3]);
            return total[PERIM_W-1:0];
        endfunction

        function void note_input(logic [IN_TDATA_W-1:0] w);
            due_q.push_back(perimeter_of(w));
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] w);
            logic [PERIM_W-1:0] want;
            if (due_q.size() == 0) begin
                $error("unexpected output word: perimeter actual %0d", w[PERIM_W-1:0]);
                mismatches++;
                return;
            end
            want = due_q.pop_front();
            if (w[PERIM_W-1:0] !== want) begin
                $error("perimeter: expected %0d, actual %0d", want, w[PERIM_W-1:0]);
                mismatches++;
            end
            if (w[OUT_TDATA_W-1:PERIM_W] !== '0) begin
                $error("zero fill: expected 0, actual %0h", w[OUT_TDATA_W-1:PERIM_W]);
                mismatches++;
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // Fields from bit 0 up: ax, ay, bx, by_coord, cx, cy (COORD_BITS each, signed).
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // Fields from bit 0 up: perimeter (PERIM_W bits, unsigned), zero fill above.
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    perimeter_board board = new();

    // Sender gaps are on unless a phase wants a dense stream; the receiver can be made
    // stall-free, and a long hold is requested by the stimulus and timed by the receiver.
    bit tx_gaps  = 1'b1;
    bit rx_quiet = 1'b0;
    bit hold_req = 1'b0;

    triangle_perimeter_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stop the run if the block hangs or loses words.
    initial begin
        #(RUN_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Idle length: mostly none or short, now and then a long one.
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Both handshakes are sampled right after the edge, so the values seen are the ones
    // that were present at the edge itself. Inputs are noted before outputs are checked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                board.note_input(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                board.check_result(m_axis_tdata);
            end
        end
    end

    // Offer one word and hold it until the block takes it. The valid is lowered only when a
    // gap follows, so it never sees two assignments in the same time step.
    task automatic send_word(input logic [IN_TDATA_W-1:0] w);
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
    endtask

    task automatic send_points(input logic [COORD_BITS-1:0] ax, input logic [COORD_BITS-1:0] ay,
                               input logic [COORD_BITS-1:0] bx, input logic [COORD_BITS-1:0] by,
                               input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy);
        send_word({cy, cx, by, bx, ay, ax});
    endtask

    function logic [COORD_BITS-1:0] extreme_coord();
        case ($urandom_range(0, 4))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            3: return COORD_NEG1;
            default: return COORD_BITS'($urandom());
        endcase
    endfunction

    // Random triangles of mixed shapes: full range, tight clusters (short sides),
    // corner and zero values, and coincident points.
    task automatic send_random(input int count);
        logic [COORD_BITS-1:0] p[6];
        int                    style;
        for (int n = 0; n < count; n++) begin
            style = $urandom_range(0, 9);
            if (style < 4) begin
                style = PTS_UNIFORM;
            end else if (style < 7) begin
                style = PTS_CLUSTER;
            end else if (style < 9) begin
                style = PTS_EXTREME;
            end else begin
                style = PTS_COINCIDENT;
            end
            for (int k = 0; k < 6; k++) begin
                p[k] = COORD_BITS'($urandom());
            end
            case (style)
                PTS_CLUSTER: begin
                    for (int k = 2; k < 6; k++) begin
                        p[k] = p[k % 2] + COORD_BITS'($urandom_range(0, 64)) - COORD_BITS'(32);
                    end
                end
                PTS_EXTREME: begin
                    for (int k = 0; k < 6; k++) begin
                        p[k] = extreme_coord();
                    end
                end
                PTS_COINCIDENT: begin
                    // Copy point A onto B, onto C, onto both, or onto neither.
                    if ($urandom_range(0, 2) != 1) begin
                        p[2] = p[0];
                        p[3] = p[1];
                    end
                    if ($urandom_range(0, 2) != 0) begin
                        p[4] = p[0];
                        p[5] = p[1];
                    end
                end
                default: begin
                end
            endcase
            send_points(p[0], p[1], p[2], p[3], p[4], p[5]);
        end
    endtask

    // Receiver: runs of ready with random stalls between them. A requested long hold keeps
    // ready low, timed by LONG_HOLD, so the pipeline fills and back-pressures the input.
    initial begin
        int run_len;
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end
            m_axis_tready <= 1'b1;
            run_len = $urandom_range(1, 12);
            repeat (run_len) @(posedge i_clk);
            if (!rx_quiet) begin
                gap = pick_gap();
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // Main stimulus: reset, directed triangles, then random phases under varying pressure.
    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fully degenerate triangles: all points at the origin, all at one corner, and all at one other point.
        send_points('0, '0, '0, '0, '0, '0);
        send_points(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        send_points(COORD_MAX, COORD_NEG1, COORD_MAX, COORD_NEG1, COORD_MAX, COORD_NEG1);
        // Two coincident points: one side is zero, the other two are equal.
        send_points(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_points('0, '0, COORD_MAX, '0, '0, '0);
        // Corner triangles give the longest sides and the largest perimeters.
        send_points(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX);
        send_points(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN);
        send_points(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        send_points(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
        // Triangles with axis-aligned sides, where the square root for those sides is exact.
        send_points(COORD_MIN, '0, COORD_MAX, '0, '0, '0);
        send_points('0, COORD_MIN, '0, COORD_MAX, COORD_MAX, COORD_MAX);
        // Unit steps around -1/0 and a 3-4-5 triangle.
        send_points(COORD_NEG1, COORD_NEG1, '0, '0, COORD_NEG1, '0);
        send_points('0, '0, 16'd3, '0, 16'd3, 16'd4);
        // Alternating bit patterns on every field.
        send_points(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'h5555);
        send_points(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA, 16'hAAAA);
        send_points(16'h00FF, 16'hFF00, 16'hFF00, 16'h00FF, 16'h0F0F, 16'hF0F0);

        // Random triangles with gaps on both sides.
        send_random(400);

        // Sender pause: let every expected word come out before going on. The first wait
        // lets the monitor note the last accepted word before the count is read.
        s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (board.pending() != 0);

        // Dense stream against a long receiver hold: the pipeline fills and stalls the input.
        tx_gaps  = 1'b0;
        hold_req = 1'b1;
        send_random(400);

        // Full-rate stretch with no idling on either side, then back to random idling.
        rx_quiet = 1'b1;
        send_random(200);
        tx_gaps  = 1'b1;
        rx_quiet = 1'b0;
        send_random(350);

        s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (board.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
